@@ hdl/cam_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cam_pkg
// Types and constants shared by the circle / box contact pipeline.
// ----------------------------------------------------------------------------
package cam_pkg;

    localparam int IN_W       = 288;
    localparam int OUT_W      = 72;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam logic signed [17:0] NORM_ONE = 18'sh10000;

    typedef struct packed {
        logic        in_box;
        logic        miss;
        logic        dx_neg;
        logic        dy_neg;
        logic        dx_nz;
        logic        dy_nz;
        logic [31:0] r2;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [33:0] din;
    } side_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
        side_t       side;
    } sq_t;

    typedef struct packed {
        logic        valid;
        logic [49:0] rem_x;
        logic [49:0] rem_y;
        logic [16:0] q_x;
        logic [16:0] q_y;
        logic [31:0] d;
        logic [33:0] cdist;
        side_t       side;
    } dv_t;

endpackage

@@ hdl/cam_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cam_front
// Offset, clamp, inside snap, contact vector, range check and squares.
// ----------------------------------------------------------------------------
module cam_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [cam_pkg::IN_W-1:0]   in_data,
    output cam_pkg::sq_t               out_sq
);
    import cam_pkg::*;

    logic [31:0] cx, cy, rr, bx, by, mnx, mxx, mny, mxy;
    logic [32:0] dbx, dby;
    logic [33:0] n1x, n1y;
    logic [32:0] e1x, e1y;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [33:0] nx1_reg, ny1_reg, nx2_reg, ny2_reg, nx3_reg, ny3_reg;
    logic [32:0] ex1_reg, ey1_reg, ex2_reg, ey2_reg;
    logic [31:0] r1_reg, r2_reg, r3_reg, r4_reg, r5_reg, r6_reg;
    logic [33:0] kx2_reg, ky2_reg, kx3_reg, ky3_reg;
    logic [33:0] anx2_reg, any2_reg;
    logic        in3_reg, in4_reg, in5_reg, in6_reg;
    logic [34:0] dx4_reg, dy4_reg;
    logic [33:0] ax5_reg, ay5_reg;
    logic        sxn5_reg, syn5_reg, sxz5_reg, syz5_reg;
    logic        sxn6_reg, syn6_reg, sxz6_reg, syz6_reg;
    logic        miss6_reg;
    logic [33:0] din6_reg;
    logic [31:0] ax6_reg, ay6_reg;
    logic [63:0] sqx6_reg, sqy6_reg, ur6_reg;
    sq_t         sq7_reg;

    logic [33:0] negex, negey, eex, eey, c1x, c1y, kx2, ky2, anx2, any2;
    logic [33:0] negex3, negey3, eex3, eey3, kx3, ky3;
    logic        in3;
    logic [34:0] dx4, dy4, tx5, ty5;
    logic        miss6;
    logic [64:0] sum7;
    sq_t         sq7;

    always_comb begin
        cx  = in_data[31:0];
        cy  = in_data[63:32];
        rr  = {1'b0, in_data[94:64]};
        bx  = in_data[126:95];
        by  = in_data[158:127];
        mnx = in_data[190:159];
        mxx = in_data[222:191];
        mny = in_data[254:223];
        mxy = in_data[286:255];
        dbx = {bx[31], bx} - {cx[31], cx};
        dby = {by[31], by} - {cy[31], cy};
        n1x = {dbx, 1'b0};
        n1y = {dby, 1'b0};
        e1x = {mxx[31], mxx} - {mnx[31], mnx};
        e1y = {mxy[31], mxy} - {mny[31], mny};

        eex   = {ex1_reg[32], ex1_reg};
        eey   = {ey1_reg[32], ey1_reg};
        negex = 34'd0 - eex;
        negey = 34'd0 - eey;
        c1x   = ($signed(nx1_reg) < $signed(negex)) ? negex : nx1_reg;
        c1y   = ($signed(ny1_reg) < $signed(negey)) ? negey : ny1_reg;
        kx2   = ($signed(c1x) > $signed(eex)) ? eex : c1x;
        ky2   = ($signed(c1y) > $signed(eey)) ? eey : c1y;
        anx2  = nx1_reg[33] ? (34'd0 - nx1_reg) : nx1_reg;
        any2  = ny1_reg[33] ? (34'd0 - ny1_reg) : ny1_reg;

        eex3   = {ex2_reg[32], ex2_reg};
        eey3   = {ey2_reg[32], ey2_reg};
        negex3 = 34'd0 - eex3;
        negey3 = 34'd0 - eey3;
        in3    = (kx2_reg == nx2_reg) && (ky2_reg == ny2_reg);
        kx3    = kx2_reg;
        ky3    = ky2_reg;
        if (in3) begin
            if (anx2_reg > any2_reg) begin
                kx3 = ($signed(nx2_reg) > 0) ? eex3 : negex3;
            end else begin
                ky3 = ($signed(ny2_reg) > 0) ? eey3 : negey3;
            end
        end

        dx4 = {nx3_reg[33], nx3_reg} - {kx3_reg[33], kx3_reg};
        dy4 = {ny3_reg[33], ny3_reg} - {ky3_reg[33], ky3_reg};

        tx5 = 35'd0 - dx4_reg;
        ty5 = 35'd0 - dy4_reg;

        miss6 = !in5_reg && ((ax5_reg > {2'b00, r5_reg}) || (ay5_reg > {2'b00, r5_reg}));

        sum7            = {1'b0, sqx6_reg} + {1'b0, sqy6_reg};
        sq7.valid       = v6_reg;
        sq7.rad         = in6_reg ? 64'd0 : sum7[63:0];
        sq7.rem         = '0;
        sq7.root        = '0;
        sq7.side.in_box = in6_reg;
        sq7.side.miss   = miss6_reg || (!in6_reg && (sum7 > {1'b0, ur6_reg}));
        sq7.side.dx_neg = sxn6_reg;
        sq7.side.dy_neg = syn6_reg;
        sq7.side.dx_nz  = sxz6_reg;
        sq7.side.dy_nz  = syz6_reg;
        sq7.side.r2     = r6_reg;
        sq7.side.ax     = ax6_reg;
        sq7.side.ay     = ay6_reg;
        sq7.side.din    = din6_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            sq7_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg   <= in_valid;
            nx1_reg  <= n1x;
            ny1_reg  <= n1y;
            ex1_reg  <= e1x;
            ey1_reg  <= e1y;
            r1_reg   <= {rr[30:0], 1'b0};

            v2_reg   <= v1_reg;
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;
            ex2_reg  <= ex1_reg;
            ey2_reg  <= ey1_reg;
            kx2_reg  <= kx2;
            ky2_reg  <= ky2;
            anx2_reg <= anx2;
            any2_reg <= any2;
            r2_reg   <= r1_reg;

            v3_reg   <= v2_reg;
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            kx3_reg  <= kx3;
            ky3_reg  <= ky3;
            in3_reg  <= in3;
            r3_reg   <= r2_reg;

            v4_reg   <= v3_reg;
            dx4_reg  <= dx4;
            dy4_reg  <= dy4;
            in4_reg  <= in3_reg;
            r4_reg   <= r3_reg;

            v5_reg   <= v4_reg;
            ax5_reg  <= dx4_reg[34] ? tx5[33:0] : dx4_reg[33:0];
            ay5_reg  <= dy4_reg[34] ? ty5[33:0] : dy4_reg[33:0];
            sxn5_reg <= dx4_reg[34];
            syn5_reg <= dy4_reg[34];
            sxz5_reg <= (dx4_reg != 35'd0);
            syz5_reg <= (dy4_reg != 35'd0);
            in5_reg  <= in4_reg;
            r5_reg   <= r4_reg;

            v6_reg    <= v5_reg;
            miss6_reg <= miss6;
            din6_reg  <= ax5_reg + ay5_reg;
            ax6_reg   <= ax5_reg[31:0];
            ay6_reg   <= ay5_reg[31:0];
            sqx6_reg  <= {32'd0, ax5_reg[31:0]} * {32'd0, ax5_reg[31:0]};
            sqy6_reg  <= {32'd0, ay5_reg[31:0]} * {32'd0, ay5_reg[31:0]};
            ur6_reg   <= {32'd0, r5_reg} * {32'd0, r5_reg};
            sxn6_reg  <= sxn5_reg;
            syn6_reg  <= syn5_reg;
            sxz6_reg  <= sxz5_reg;
            syz6_reg  <= syz5_reg;
            in6_reg   <= in5_reg;
            r6_reg    <= r5_reg;

            sq7_reg   <= sq7;
        end
    end

    assign out_sq = sq7_reg;

endmodule

@@ hdl/cam_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cam_sqrt_cell
// One root bit of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module cam_sqrt_cell (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  cam_pkg::sq_t in_sq,
    output cam_pkg::sq_t out_sq
);
    import cam_pkg::*;

    sq_t         sq_reg, sq_next;
    logic [34:0] rem_s, trial;
    logic        ge;

    always_comb begin
        rem_s   = {in_sq.rem[32:0], in_sq.rad[63:62]};
        trial   = {1'b0, in_sq.root, 2'b01};
        ge      = (rem_s >= trial);
        sq_next = in_sq;
        sq_next.rad  = {in_sq.rad[61:0], 2'b00};
        sq_next.rem  = ge ? (rem_s - trial) : rem_s;
        sq_next.root = {in_sq.root[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg.valid <= 1'b0;
        end else if (en) begin
            sq_reg <= sq_next;
        end
    end

    assign out_sq = sq_reg;

endmodule

@@ hdl/cam_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cam_div_cell
// One quotient bit of the restoring division for both normal components.
// ----------------------------------------------------------------------------
module cam_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  cam_pkg::dv_t in_dv,
    output cam_pkg::dv_t out_dv
);
    import cam_pkg::*;

    dv_t         dv_reg, dv_next;
    logic [49:0] trial;
    logic        gex, gey;

    always_comb begin
        trial   = {18'd0, in_dv.d} << SHIFT;
        gex     = (in_dv.rem_x >= trial);
        gey     = (in_dv.rem_y >= trial);
        dv_next = in_dv;
        dv_next.rem_x = gex ? (in_dv.rem_x - trial) : in_dv.rem_x;
        dv_next.rem_y = gey ? (in_dv.rem_y - trial) : in_dv.rem_y;
        dv_next.q_x   = {in_dv.q_x[15:0], gex};
        dv_next.q_y   = {in_dv.q_y[15:0], gey};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg.valid <= 1'b0;
        end else if (en) begin
            dv_reg <= dv_next;
        end
    end

    assign out_dv = dv_reg;

endmodule

@@ hdl/circle_aabb_manifold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_aabb_manifold
// Contact result for one circle / axis-aligned box pair per word.
// ----------------------------------------------------------------------------
// The block takes one pair per clock while the pipeline advances and gives one
// result word per pair, in order, through seven front stages, a chain of 32
// square root cells, one stage that forms the dividends, a chain of 17 divider
// cells and the output register. The whole pipeline advances whenever the
// output register is empty or its word is being taken.
module circle_aabb_manifold (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // circle_x, circle_y, circle_radius, box_x, box_y, box_min_x, box_max_x,
    // box_min_y, box_max_y, one zero pad bit
    input  logic [cam_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // colliding, center_inside, degenerate, contact_normal_x,
    // contact_normal_y, penetration_depth, one zero pad bit
    output logic [cam_pkg::OUT_W-1:0] m_tdata
);
    import cam_pkg::*;

    logic        en;
    sq_t         sq_w [0:SQRT_STEPS];
    dv_t         dv_w [0:DIV_STEPS];
    dv_t         dv_reg, dv_next;
    logic        m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic [33:0]        dist_n;
    side_t              so;
    logic               degen;
    logic signed [17:0] nrx, nry;
    logic [35:0]        pdiff;
    logic [34:0]        phalf;
    logic [31:0]        pen;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    cam_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .out_sq   (sq_w[0])
    );

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        cam_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_sq   (sq_w[i]),
            .out_sq  (sq_w[i+1])
        );
    end

    always_comb begin
        dist_n        = sq_w[SQRT_STEPS].side.in_box ? sq_w[SQRT_STEPS].side.din
                                                     : {2'b00, sq_w[SQRT_STEPS].root};
        dv_next.valid = sq_w[SQRT_STEPS].valid;
        dv_next.rem_x = {2'b00, sq_w[SQRT_STEPS].side.ax, 16'd0}
                      + {19'd0, sq_w[SQRT_STEPS].root[31:1]};
        dv_next.rem_y = {2'b00, sq_w[SQRT_STEPS].side.ay, 16'd0}
                      + {19'd0, sq_w[SQRT_STEPS].root[31:1]};
        dv_next.q_x   = '0;
        dv_next.q_y   = '0;
        dv_next.d     = sq_w[SQRT_STEPS].root;
        dv_next.cdist = dist_n;
        dv_next.side  = sq_w[SQRT_STEPS].side;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg.valid <= 1'b0;
        end else if (en) begin
            dv_reg <= dv_next;
        end
    end

    assign dv_w[0] = dv_reg;

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        cam_div_cell #(
            .SHIFT (DIV_STEPS - 1 - j)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_dv   (dv_w[j]),
            .out_dv  (dv_w[j+1])
        );
    end

    always_comb begin
        so    = dv_w[DIV_STEPS].side;
        degen = (dv_w[DIV_STEPS].cdist == 34'd0);
        if (degen) begin
            nrx = '0;
            nry = '0;
        end else if (so.in_box) begin
            nrx = so.dx_nz ? (so.dx_neg ? NORM_ONE : -NORM_ONE) : 18'sd0;
            nry = so.dy_nz ? (so.dy_neg ? NORM_ONE : -NORM_ONE) : 18'sd0;
        end else begin
            nrx = so.dx_neg ? -$signed({1'b0, dv_w[DIV_STEPS].q_x})
                            : $signed({1'b0, dv_w[DIV_STEPS].q_x});
            nry = so.dy_neg ? -$signed({1'b0, dv_w[DIV_STEPS].q_y})
                            : $signed({1'b0, dv_w[DIV_STEPS].q_y});
        end
        pdiff = {4'd0, so.r2} - {2'b00, dv_w[DIV_STEPS].cdist};
        phalf = pdiff[35:1];
        if ($signed(phalf) > $signed(35'sh7FFFFFFF)) begin
            pen = 32'h7FFFFFFF;
        end else if ($signed(phalf) < -$signed(35'sh80000000)) begin
            pen = 32'h80000000;
        end else begin
            pen = phalf[31:0];
        end
        if (so.miss) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = {1'b0, pen, nry, nrx, degen, so.in_box, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_w[DIV_STEPS].valid;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hdl/cam_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cam_checker
// Port-level checks of the contact pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module cam_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [cam_pkg::IN_W-1:0]  s_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [cam_pkg::OUT_W-1:0] m_tdata
);
    import cam_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word present right after reset");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_W-1:1] == '0))
        else $error("miss word carries nonzero fields");

    a_degen_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[0] && m_tdata[38:3] == '0))
        else $error("degenerate word with a normal or without contact");

    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output register");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

endmodule

bind circle_aabb_manifold cam_checker u_cam_checker (.*);
